// ===== sv/mct_pkg.sv =====
// Package for the multi-slot countdown timer: widths, codes and the command type.
`default_nettype none
package mct_pkg;

  localparam int unsigned DEF_SLOTS       = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 32;
  localparam int unsigned MAX_RESULTS     = 16;
  localparam int unsigned DELAY_W         = 32;
  localparam int unsigned TAG_W           = 16;
  localparam int unsigned HANDLE_W        = 4;
  localparam int unsigned CMDQ_DEPTH      = 2;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_START_ONCE = 2'd1,
    FUNC_START_REP  = 2'd2,
    FUNC_CANCEL     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_FIRED    = 2'd0,
    KIND_STARTED  = 2'd1,
    KIND_FULL     = 2'd2,
    KIND_CANCELED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_START  = 2'd1,
    OP_CANCEL = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic                once;
    logic                due;
    logic [TAG_W-1:0]    tag;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

endpackage
`default_nettype wire

// ===== sv/mct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/mct_front.sv =====
// Front end: accepts input transfers and classifies them into timer commands.
`default_nettype none
module mct_front
  import mct_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             func_i,
  input  wire logic [DELAY_W-1:0]     delay_ticks_i,
  input  wire logic [TAG_W-1:0]       user_tag_i,
  input  wire logic [HANDLE_W-1:0]    slot_handle_i,
  input  wire logic                   q_full_i,
  output logic                        q_push_o,
  output cmd_t                        q_cmd_o,
  output logic      [COUNT_WIDTH-1:0] q_delay_o
);

  logic [COUNT_WIDTH-1:0] delay;

  assign delay      = COUNT_WIDTH'(delay_ticks_i);
  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_delay_o  = delay;

  always_comb begin
    q_cmd_o        = '0;
    q_cmd_o.tag    = user_tag_i;
    q_cmd_o.handle = slot_handle_i;
    q_cmd_o.due    = (delay == COUNT_WIDTH'(1));
    case (func_e'(func_i))
      FUNC_TICK: begin
        q_cmd_o.op = OP_TICK;
      end
      FUNC_START_ONCE: begin
        q_cmd_o.op   = OP_START;
        q_cmd_o.once = 1'b1;
      end
      FUNC_START_REP: begin
        q_cmd_o.op   = OP_START;
        q_cmd_o.once = (delay == '0);
      end
      FUNC_CANCEL: begin
        q_cmd_o.op = OP_CANCEL;
      end
      default: begin
        q_cmd_o.op = OP_TICK;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/mct_cmdq.sv =====
// Short command queue between the front end and the slot engine.
`default_nettype none
module mct_cmdq
  import mct_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o
);
  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  logic [WIDTH-1:0] buf_q [CMDQ_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/mct_back.sv =====
// Slot engine: slot table, tick walk over the slot RAM and the result register.
`default_nettype none
module mct_back
  import mct_pkg::*;
#(
  parameter int unsigned SLOTS       = DEF_SLOTS,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cmd_valid_i,
  input  wire cmd_t                   cmd_i,
  input  wire logic [COUNT_WIDTH-1:0] cmd_delay_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [1:0]             kind_o,
  output logic      [HANDLE_W-1:0]    handle_o,
  output logic      [TAG_W-1:0]       tag_o,
  output logic                        found_o,
  output logic                        active_o,
  output logic                        last_o
);
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned NW   = $clog2(SLOTS + 1);
  localparam int unsigned RW   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned WW   = TAG_W + 2 * CW;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TICK = 2'b10
  } state_e;

  state_e              state_q, state_d;
  logic [SLOTS-1:0]    valid_q, valid_d, due_q, due_d, once_q, once_d;
  logic [NW-1:0]       rd_cnt_q, rd_cnt_d;
  logic                s1_v_q, s1_v_d;
  logic [IW-1:0]       s1_idx_q, s1_idx_d;
  logic                hv_q, hv_d;
  logic [IW-1:0]       h_idx_q, h_idx_d;
  logic [TAG_W-1:0]    h_tag_q, h_tag_d;
  logic [RW-1:0]       nf_q, nf_d;
  logic                act_q, act_d;

  logic                out_v_q;
  logic [1:0]          kind_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [TAG_W-1:0]    tag_q;
  logic                found_q, active_q, last_q;

  logic                out_free, out_load;
  kind_e               o_kind;
  logic [HANDLE_W-1:0] o_handle;
  logic [TAG_W-1:0]    o_tag;
  logic                o_found, o_active, o_last;

  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  logic [WW-1:0]       ram_wdata, ram_rdata;

  logic [CW-1:0]       cnt_r, rel_r, dec;
  logic [TAG_W-1:0]    tag_r;
  logic [IW-1:0]       free_idx;
  logic                any_free;
  logic [SLOTS-1:0]    cancel_mask;
  logic                vld_s1, fire, report, rd_done, stall;

  assign cnt_r   = ram_rdata[CW-1:0];
  assign rel_r   = ram_rdata[2*CW-1:CW];
  assign tag_r   = ram_rdata[WW-1:2*CW];
  assign dec     = cnt_r - CW'(1);
  assign vld_s1  = valid_q[s1_idx_q];
  assign rd_done = (rd_cnt_q == NW'(SLOTS));
  assign fire    = s1_v_q && vld_s1 && (dec == '0);
  assign report  = fire && (nf_q < RW'(MAX_RESULTS));
  assign out_free = !out_v_q || out_ready_i;
  assign stall   = report && hv_q && !out_free;
  assign any_free = !(&valid_q);

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      cancel_mask[i] = (int'(cmd_i.handle) == i);
    end
  end

  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    due_d     = due_q;
    once_d    = once_q;
    rd_cnt_d  = rd_cnt_q;
    s1_v_d    = s1_v_q;
    s1_idx_d  = s1_idx_q;
    hv_d      = hv_q;
    h_idx_d   = h_idx_q;
    h_tag_d   = h_tag_q;
    nf_d      = nf_q;
    act_d     = act_q;
    cmd_pop_o = 1'b0;
    out_load  = 1'b0;
    o_kind    = KIND_FIRED;
    o_handle  = '0;
    o_tag     = '0;
    o_found   = 1'b0;
    o_active  = 1'b0;
    o_last    = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = s1_idx_q;
    ram_wdata = {tag_r, rel_r, dec};
    ram_re    = 1'b0;
    ram_raddr = rd_cnt_q[IW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.op)
            OP_TICK: begin
              cmd_pop_o = 1'b1;
              state_d   = ST_TICK;
              rd_cnt_d  = '0;
              s1_v_d    = 1'b0;
              hv_d      = 1'b0;
              nf_d      = '0;
              act_d     = |(valid_q & ~(due_q & once_q));
            end
            OP_START: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                out_load  = 1'b1;
                if (any_free) begin
                  valid_d[free_idx] = 1'b1;
                  due_d[free_idx]   = cmd_i.due;
                  once_d[free_idx]  = cmd_i.once;
                  ram_we    = 1'b1;
                  ram_waddr = free_idx;
                  ram_wdata = {cmd_i.tag, (cmd_i.once ? CW'(0) : cmd_delay_i), cmd_delay_i};
                  o_kind    = KIND_STARTED;
                  o_handle  = HANDLE_W'(free_idx);
                end else begin
                  o_kind    = KIND_FULL;
                end
                o_active = 1'b1;
              end
            end
            OP_CANCEL: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                out_load  = 1'b1;
                valid_d   = valid_q & ~cancel_mask;
                o_kind    = KIND_CANCELED;
                o_handle  = cmd_i.handle;
                o_found   = |(valid_q & cancel_mask);
                o_active  = |(valid_q & ~cancel_mask);
              end
            end
            default: begin
              cmd_pop_o = 1'b1;
            end
          endcase
        end
      end

      ST_TICK: begin
        if (!stall) begin
          if (s1_v_q && vld_s1) begin
            if (dec == '0) begin
              if (rel_r == '0) begin
                valid_d[s1_idx_q] = 1'b0;
              end else begin
                ram_we               = 1'b1;
                ram_wdata            = {tag_r, rel_r, rel_r};
                due_d[s1_idx_q]      = (rel_r == CW'(1));
              end
            end else begin
              ram_we          = 1'b1;
              due_d[s1_idx_q] = (dec == CW'(1));
            end
          end
          if (report) begin
            if (hv_q) begin
              out_load = 1'b1;
              o_handle = HANDLE_W'(h_idx_q);
              o_tag    = h_tag_q;
              o_active = act_q;
              o_last   = 1'b0;
            end
            hv_d    = 1'b1;
            h_idx_d = s1_idx_q;
            h_tag_d = tag_r;
            nf_d    = nf_q + RW'(1);
          end
          if (!rd_done) begin
            ram_re   = 1'b1;
            s1_v_d   = 1'b1;
            s1_idx_d = rd_cnt_q[IW-1:0];
            rd_cnt_d = rd_cnt_q + NW'(1);
          end else begin
            s1_v_d = 1'b0;
          end
          if (rd_done && !s1_v_q) begin
            if (!hv_q) begin
              state_d = ST_IDLE;
            end else if (out_free) begin
              out_load = 1'b1;
              o_handle = HANDLE_W'(h_idx_q);
              o_tag    = h_tag_q;
              o_active = act_q;
              o_last   = 1'b1;
              hv_d     = 1'b0;
              state_d  = ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  mct_ram #(
    .WIDTH(WW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      due_q    <= '0;
      once_q   <= '0;
      rd_cnt_q <= '0;
      s1_v_q   <= 1'b0;
      s1_idx_q <= '0;
      hv_q     <= 1'b0;
      nf_q     <= '0;
      act_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      due_q    <= due_d;
      once_q   <= once_d;
      rd_cnt_q <= rd_cnt_d;
      s1_v_q   <= s1_v_d;
      s1_idx_q <= s1_idx_d;
      hv_q     <= hv_d;
      nf_q     <= nf_d;
      act_q    <= act_d;
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h_idx_q <= h_idx_d;
    h_tag_q <= h_tag_d;
    if (out_load) begin
      kind_q   <= o_kind;
      handle_q <= o_handle;
      tag_q    <= o_tag;
      found_q  <= o_found;
      active_q <= o_active;
      last_q   <= o_last;
    end
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = kind_q;
  assign handle_o    = handle_q;
  assign tag_o       = tag_q;
  assign found_o     = found_q;
  assign active_o    = active_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ===== sv/multi_slot_countdown_timer_core.sv =====
// Top level of the multi-slot countdown timer.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   func, delay_ticks, user_tag, slot_handle
//   out      output     out_valid_o / out_ready_i kind, handle, tag, found, active, last
//
// Start and cancel are handled in the slot engine in the same cycle that they leave the command queue.
// A tick leaves the queue, then walks every slot through the slot RAM read port, one slot
// per cycle except while the result register stalls on out_ready_i.
// Reset clears the slot valid bits; the slot RAM needs no clearing.
// The two-entry command queue keeps taking transfers while a tick walk is busy.
`default_nettype none
module multi_slot_countdown_timer_core
  import mct_pkg::*;
#(
  parameter int unsigned SLOTS       = DEF_SLOTS,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          func_i,
  input  wire logic [DELAY_W-1:0]  delay_ticks_i,
  input  wire logic [TAG_W-1:0]    user_tag_i,
  input  wire logic [HANDLE_W-1:0] slot_handle_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic      [1:0]          kind_o,
  output logic      [HANDLE_W-1:0] handle_o,
  output logic      [TAG_W-1:0]    tag_o,
  output logic                     found_o,
  output logic                     active_o,
  output logic                     last_o
);
  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned QW    = CMD_W + COUNT_WIDTH;

  logic                   q_full, q_push, q_valid, q_pop;
  cmd_t                   f_cmd, b_cmd;
  logic [COUNT_WIDTH-1:0] f_delay, b_delay;
  logic [QW-1:0]          q_rdata;

  mct_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .delay_ticks_i(delay_ticks_i),
    .user_tag_i   (user_tag_i),
    .slot_handle_i(slot_handle_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (f_cmd),
    .q_delay_o    (f_delay)
  );

  mct_cmdq #(
    .WIDTH(QW)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i ({f_cmd, f_delay}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_rdata)
  );

  assign b_cmd   = cmd_t'(q_rdata[QW-1:COUNT_WIDTH]);
  assign b_delay = q_rdata[COUNT_WIDTH-1:0];

  mct_back #(
    .SLOTS      (SLOTS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(q_valid),
    .cmd_i      (b_cmd),
    .cmd_delay_i(b_delay),
    .cmd_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .kind_o     (kind_o),
    .handle_o   (handle_o),
    .tag_o      (tag_o),
    .found_o    (found_o),
    .active_o   (active_o),
    .last_o     (last_o)
  );

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the multi-slot countdown timer core: directed and random traffic checked against a slot-table predictor.
module tb_top;
  import mct_pkg::*;

  localparam int unsigned SLOTS          = DEF_SLOTS;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 2 * SLOTS + 8;

  typedef struct packed {
    kind_e               kind;
    logic [HANDLE_W-1:0] handle;
    logic [TAG_W-1:0]    tag;
    logic                found;
    logic                active;
    logic                last;
  } timer_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                in_valid_i    = 1'b0;
  logic                in_ready_o;
  logic [1:0]          func_i        = FUNC_TICK;
  logic [DELAY_W-1:0]  delay_ticks_i = '0;
  logic [TAG_W-1:0]    user_tag_i    = '0;
  logic [HANDLE_W-1:0] slot_handle_i = '0;
  logic                out_valid_o;
  logic                out_ready_i   = 1'b0;
  logic [1:0]          kind_o;
  logic [HANDLE_W-1:0] handle_o;
  logic [TAG_W-1:0]    tag_o;
  logic                found_o;
  logic                active_o;
  logic                last_o;

  // Predicted slot table
  logic                       slot_busy   [SLOTS] = '{default: 1'b0};
  logic [DEF_COUNT_WIDTH-1:0] slot_left   [SLOTS];
  logic [DEF_COUNT_WIDTH-1:0] slot_period [SLOTS];
  logic [TAG_W-1:0]           slot_owner  [SLOTS];

  timer_result_t pending_results[$];

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  bit          hold_flip  = 1'b0;
  bit          hold_seen  = 1'b0;
  int unsigned hold_left  = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors     = 0;
  int unsigned in_count   = 0;
  int unsigned out_count  = 0;
  int unsigned fire_count = 0;
  int unsigned full_count = 0;

  multi_slot_countdown_timer_core #(
    .SLOTS      (SLOTS),
    .COUNT_WIDTH(DEF_COUNT_WIDTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .delay_ticks_i(delay_ticks_i),
    .user_tag_i   (user_tag_i),
    .slot_handle_i(slot_handle_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .handle_o     (handle_o),
    .tag_o        (tag_o),
    .found_o      (found_o),
    .active_o     (active_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned count_busy();
    int unsigned n;
    n = 0;
    foreach (slot_busy[i]) n += slot_busy[i];
    return n;
  endfunction

  function automatic void predict_timer_results(func_e f, logic [DELAY_W-1:0] delay,
                                                logic [TAG_W-1:0] utag,
                                                logic [HANDLE_W-1:0] sh);
    timer_result_t step_q[$];
    timer_result_t r;
    int            free_slot;
    logic          any_busy;
    free_slot = -1;
    any_busy  = 1'b0;
    r         = '0;
    case (f)
      FUNC_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i]) begin
            slot_left[i] = slot_left[i] - 1'b1;
            if (slot_left[i] == '0) begin
              if (step_q.size() < MAX_RESULTS) begin
                r        = '0;
                r.kind   = KIND_FIRED;
                r.handle = HANDLE_W'(i);
                r.tag    = slot_owner[i];
                step_q.insert(step_q.size(), r);
              end
              if (slot_period[i] == '0) slot_busy[i] = 1'b0;
              else slot_left[i] = slot_period[i];
            end
          end
        end
      end
      FUNC_START_ONCE, FUNC_START_REP: begin
        for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) free_slot = i;
        if (free_slot >= 0) begin
          slot_busy[free_slot]   = 1'b1;
          slot_left[free_slot]   = DEF_COUNT_WIDTH'(delay);
          slot_period[free_slot] = (f == FUNC_START_REP) ? DEF_COUNT_WIDTH'(delay) : '0;
          slot_owner[free_slot]  = utag;
          r.kind   = KIND_STARTED;
          r.handle = HANDLE_W'(free_slot);
        end else begin
          r.kind = KIND_FULL;
        end
        step_q.insert(step_q.size(), r);
      end
      default: begin
        r.kind   = KIND_CANCELED;
        r.handle = sh;
        if (sh < SLOTS && slot_busy[sh]) begin
          slot_busy[sh] = 1'b0;
          r.found       = 1'b1;
        end
        step_q.insert(step_q.size(), r);
      end
    endcase
    foreach (slot_busy[i]) any_busy |= slot_busy[i];
    foreach (step_q[k]) begin
      step_q[k].active = any_busy;
      step_q[k].last   = (k == step_q.size() - 1);
      pending_results.insert(pending_results.size(), step_q[k]);
    end
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return DELAY_W'($urandom_range(6, 1));
    if (sel < 80) return '0;
    if (sel < 90) return DELAY_W'($urandom_range(40, 7));
    return DELAY_W'($urandom);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Sender: optional idle gap, then hold the item until the transfer.
  task automatic send_item(func_e f, logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] utag,
                           logic [HANDLE_W-1:0] sh);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    func_i        = f;
    delay_ticks_i = delay;
    user_tag_i    = utag;
    slot_handle_i = sh;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timer_results(f, delay, utag, sh);
    in_count++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_start(func_e f, logic [DELAY_W-1:0] delay);
    send_item(f, delay, TAG_W'($urandom), HANDLE_W'($urandom));
  endtask

  task automatic cancel_all_slots();
    for (int h = 0; h < SLOTS; h++) send_item(FUNC_CANCEL, DELAY_W'($urandom), '0, HANDLE_W'(h));
  endtask

  task automatic test_directed_extremes();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(FUNC_START_ONCE, '0, '0, '0);   // zero delay wraps the count
    send_item(FUNC_START_REP, '1, '1, '1);
    send_item(FUNC_START_ONCE, 32'd1, 16'hA5A5, 4'h5);
    send_item(FUNC_START_REP, 32'd2, 16'h5A5A, 4'hA);
    send_item(FUNC_START_ONCE, 32'd1, 16'h8001, '0);
    send_item(FUNC_TICK, '1, '1, '1);         // two fires, ascending
    send_item(FUNC_TICK, '0, '0, '0);         // repeating slot fires and reloads
    send_item(FUNC_TICK, 32'h5555_5555, 16'h5555, 4'h5);  // nothing fires
    send_item(FUNC_TICK, 32'hAAAA_AAAA, 16'hAAAA, 4'hA);
    send_item(FUNC_CANCEL, '0, '0, 4'hF);     // free slot
    send_item(FUNC_CANCEL, '1, '1, 4'h0);
    send_item(FUNC_CANCEL, '0, '0, 4'h1);
    send_item(FUNC_CANCEL, '0, '0, 4'h3);
    send_item(FUNC_CANCEL, '0, '0, 4'h3);     // already freed
    send_item(FUNC_CANCEL, '0, '0, 4'h2);
  endtask

  task automatic test_table_full();
    idle_pct  = 25;
    stall_pct = 25;
    while (count_busy() < SLOTS)
      send_start($urandom_range(1) ? FUNC_START_REP : FUNC_START_ONCE,
                 DELAY_W'($urandom_range(60, 3)));
    send_start(FUNC_START_ONCE, 32'd1);
    send_start(FUNC_START_REP, '1);
    send_item(FUNC_TICK, '0, '0, '0);
    cancel_all_slots();
  endtask

  task automatic test_all_fire_same_tick();
    idle_pct  = 0;
    stall_pct = 0;
    for (int i = 0; i < SLOTS; i++) send_start(i[0] ? FUNC_START_REP : FUNC_START_ONCE, 32'd1);
    send_item(FUNC_TICK, '0, '0, '0);
    send_item(FUNC_TICK, '1, '1, '1);
    cancel_all_slots();
  endtask

  task automatic test_output_hold_off();
    idle_pct  = 0;
    stall_pct = 0;
    hold_flip = ~hold_flip;
    for (int i = 0; i < 8; i++) send_start(FUNC_START_REP, DELAY_W'($urandom_range(2, 1)));
    for (int i = 0; i < 24; i++) send_item(FUNC_TICK, DELAY_W'($urandom), '0, '0);
    cancel_all_slots();
  endtask

  task automatic test_random_traffic(int unsigned idle, int unsigned stall, int unsigned n);
    int unsigned         sel;
    logic [HANDLE_W-1:0] h;
    idle_pct  = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (sel < 40) begin
        send_item(FUNC_TICK, DELAY_W'($urandom), TAG_W'($urandom), HANDLE_W'($urandom));
      end else if (sel < 75) begin
        send_start(sel < 57 ? FUNC_START_ONCE : FUNC_START_REP, pick_delay());
      end else begin
        h = HANDLE_W'($urandom);
        if (count_busy() > 0 && $urandom_range(3) != 0)
          while (!slot_busy[h]) h = HANDLE_W'($urandom);
        send_item(FUNC_CANCEL, DELAY_W'($urandom), TAG_W'($urandom), h);
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_flip != hold_seen) begin
      hold_seen = hold_flip;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready_i = 1'b0;
      hold_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    timer_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      out_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d handle %0d tag %0h",
                 $time, kind_o, handle_o, tag_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.kind == KIND_FIRED) fire_count++;
        if (exp_r.kind == KIND_FULL) full_count++;
        check_field("kind", exp_r.kind, kind_o);
        check_field("handle", exp_r.handle, handle_o);
        check_field("tag", exp_r.tag, tag_o);
        check_field("found", exp_r.found, found_o);
        check_field("active", exp_r.active, active_o);
        check_field("last", exp_r.last, last_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending_results.size());
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed_extremes();
    test_table_full();
    test_all_fire_same_tick();
    test_output_hold_off();
    test_random_traffic(0, 0, 55);
    test_random_traffic(88, 0, 55);
    test_random_traffic(0, 88, 55);
    test_random_traffic(25, 25, 55);
    idle_pct = 0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d input transfers and %0d result transfers (%0d fires, %0d full-table)",
             in_count, out_count, fire_count, full_count);
    $display("under four idle/stall mixes plus a %0d-cycle output hold-off.", HOLD_CYCLES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
